// ===== hw/rtl/ftlru_pkg.sv =====
// Shared constants, request codes and types for the LRU frame table.
`timescale 1ns / 1ps
package ftlru_pkg;

    localparam int FRAME_COUNT = 64;
    localparam int PID_BITS    = 8;
    localparam int PAGE_BITS   = 10;
    localparam int STAMP_BITS  = 32;
    localparam int IDX_BITS    = $clog2(FRAME_COUNT);
    localparam int CNT_BITS    = $clog2(FRAME_COUNT + 1);

    localparam logic [2:0] KIND_TOUCH   = 3'd0;
    localparam logic [2:0] KIND_PLACE   = 3'd1;
    localparam logic [2:0] KIND_GLOBAL  = 3'd2;
    localparam logic [2:0] KIND_LOCAL   = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    typedef struct packed {
        logic [PID_BITS-1:0]   owner;
        logic [PAGE_BITS-1:0]  page;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic                  free_found;
        logic [IDX_BITS-1:0]   free_idx;
        logic                  best_found;
        logic [IDX_BITS-1:0]   best_idx;
        logic [PID_BITS-1:0]   best_owner;
        logic [PAGE_BITS-1:0]  best_page;
    } search_t;

endpackage

// ===== hw/rtl/ftlru_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ftlru_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/ftlru_search.sv =====
// Scan tracker: lowest free frame and oldest candidate frame over a table sweep.
`timescale 1ns / 1ps
module ftlru_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic                             en,
    input  logic                             local_only,
    input  logic [ftlru_pkg::PID_BITS-1:0]   pid,
    input  logic [ftlru_pkg::IDX_BITS-1:0]   idx,
    input  logic                             frame_valid,
    input  ftlru_pkg::entry_t                entry,
    output ftlru_pkg::search_t               res
);

    logic                                free_found_reg;
    logic [ftlru_pkg::IDX_BITS-1:0]      free_idx_reg;
    logic                                best_found_reg;
    logic [ftlru_pkg::IDX_BITS-1:0]      best_idx_reg;
    logic [ftlru_pkg::PID_BITS-1:0]      best_owner_reg;
    logic [ftlru_pkg::PAGE_BITS-1:0]     best_page_reg;
    logic [ftlru_pkg::STAMP_BITS-1:0]    best_stamp_reg;
    logic                                take_free;
    logic                                take_best;

    assign take_free = en && !frame_valid && !free_found_reg;
    assign take_best = en && frame_valid && (!local_only || entry.owner == pid)
                       && (!best_found_reg || entry.stamp < best_stamp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (clear)
        begin
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (take_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_free)
        begin
            free_idx_reg <= idx;
        end
        if (take_best)
        begin
            best_idx_reg   <= idx;
            best_owner_reg <= entry.owner;
            best_page_reg  <= entry.page;
            best_stamp_reg <= entry.stamp;
        end
    end

    assign res.free_found = free_found_reg;
    assign res.free_idx   = free_idx_reg;
    assign res.best_found = best_found_reg;
    assign res.best_idx   = best_idx_reg;
    assign res.best_owner = best_owner_reg;
    assign res.best_page  = best_page_reg;

endmodule

// ===== hw/rtl/frame_table_lru_replacement.sv =====
// Top level of the LRU frame table: request sequencer, valid marks and frame count.
// Touch and release: after acceptance the entry is read in ST_FETCH, then updated in ST_APPLY, which raises done.
// Place, global and local replace: one RAM read per frame, sweeping all FRAME_COUNT frames
//   in ST_SCAN, then ST_DRAIN and ST_DECIDE, which raises done.
// Unused kinds: done is raised in the cycle after acceptance. A new request is taken the cycle done shows.
// Reset clears all valid marks and the count; frame contents stay undefined until written.
// Results stand for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
module frame_table_lru_replacement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [5:0]  frame_index,
    input  logic [7:0]  owner_pid,
    input  logic [9:0]  page_number,
    input  logic [31:0] now,
    output logic        done,
    output logic [5:0]  chosen_frame,
    output logic        not_found,
    output logic        evicted_valid,
    output logic [7:0]  evicted_pid,
    output logic [9:0]  evicted_page,
    output logic [6:0]  frames_in_use
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FETCH,
        ST_APPLY
    } state_t;

    state_t                                state_reg;
    logic [ftlru_pkg::FRAME_COUNT-1:0]     valid_reg;
    logic [ftlru_pkg::CNT_BITS-1:0]        count_reg;
    logic [ftlru_pkg::IDX_BITS-1:0]        cnt_reg;
    logic                                  pend_reg;
    logic [ftlru_pkg::IDX_BITS-1:0]        pidx_reg;
    logic                                  pfv_reg;
    logic [2:0]                            kind_reg;
    logic [5:0]                            idx_reg;
    logic [ftlru_pkg::PID_BITS-1:0]        pid_reg;
    logic [ftlru_pkg::PAGE_BITS-1:0]       page_reg;
    logic [31:0]                           now_reg;
    logic                                  done_reg;
    logic [5:0]                            chosen_reg;
    logic                                  nf_reg;
    logic                                  ev_reg;
    logic [7:0]                            evpid_reg;
    logic [9:0]                            evpage_reg;

    logic                                  accept;
    logic                                  ram_we;
    logic [ftlru_pkg::IDX_BITS-1:0]        ram_waddr;
    ftlru_pkg::entry_t                     ram_wdata;
    logic                                  ram_re;
    logic [ftlru_pkg::IDX_BITS-1:0]        ram_raddr;
    logic [ftlru_pkg::ENTRY_BITS-1:0]      ram_rdata;
    ftlru_pkg::entry_t                     rd_entry;
    ftlru_pkg::search_t                    srch;
    logic [ftlru_pkg::IDX_BITS-1:0]        req_addr;
    logic                                  in_range;
    logic                                  hit;
    logic                                  fill_ok;
    logic [ftlru_pkg::IDX_BITS-1:0]        fill_idx;
    logic                                  fill_evict;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign rd_entry = ram_rdata;
    assign req_addr = ftlru_pkg::IDX_BITS'(idx_reg);
    assign in_range = (32'(idx_reg) < 32'(ftlru_pkg::FRAME_COUNT));
    assign hit      = in_range && valid_reg[req_addr];

    always_comb
    begin
        fill_ok    = 1'b0;
        fill_idx   = srch.free_idx;
        fill_evict = 1'b0;
        unique case (kind_reg)
            ftlru_pkg::KIND_PLACE:
            begin
                fill_ok = srch.free_found;
            end
            ftlru_pkg::KIND_GLOBAL:
            begin
                fill_ok    = srch.free_found || srch.best_found;
                fill_idx   = srch.free_found ? srch.free_idx : srch.best_idx;
                fill_evict = !srch.free_found;
            end
            ftlru_pkg::KIND_LOCAL:
            begin
                fill_ok    = srch.best_found;
                fill_idx   = srch.best_idx;
                fill_evict = 1'b1;
            end
            default:
            begin
                fill_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_re          = (state_reg == ST_SCAN) || (state_reg == ST_FETCH);
        ram_raddr       = (state_reg == ST_SCAN) ? cnt_reg : req_addr;
        ram_we          = 1'b0;
        ram_waddr       = fill_idx;
        ram_wdata.owner = pid_reg;
        ram_wdata.page  = page_reg;
        ram_wdata.stamp = now_reg;
        if (state_reg == ST_DECIDE)
        begin
            ram_we = fill_ok;
        end
        else if (state_reg == ST_APPLY && kind_reg == ftlru_pkg::KIND_TOUCH)
        begin
            ram_we          = hit;
            ram_waddr       = req_addr;
            ram_wdata.owner = rd_entry.owner;
            ram_wdata.page  = rd_entry.page;
        end
    end

    ftlru_ram #(
        .DEPTH (ftlru_pkg::FRAME_COUNT),
        .WIDTH (ftlru_pkg::ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ftlru_search u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .en          (pend_reg),
        .local_only  (kind_reg == ftlru_pkg::KIND_LOCAL),
        .pid         (pid_reg),
        .idx         (pidx_reg),
        .frame_valid (pfv_reg),
        .entry       (rd_entry),
        .res         (srch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            count_reg  <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            chosen_reg <= '0;
            nf_reg     <= 1'b0;
            ev_reg     <= 1'b0;
            evpid_reg  <= '0;
            evpage_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        idx_reg  <= frame_index;
                        pid_reg  <= ftlru_pkg::PID_BITS'(owner_pid);
                        page_reg <= ftlru_pkg::PAGE_BITS'(page_number);
                        now_reg  <= now;
                        cnt_reg  <= '0;
                        unique case (kind)
                            ftlru_pkg::KIND_TOUCH,
                            ftlru_pkg::KIND_RELEASE:
                            begin
                                state_reg <= ST_FETCH;
                            end
                            ftlru_pkg::KIND_PLACE,
                            ftlru_pkg::KIND_GLOBAL,
                            ftlru_pkg::KIND_LOCAL:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                chosen_reg <= '0;
                                nf_reg     <= 1'b0;
                                ev_reg     <= 1'b0;
                                evpid_reg  <= '0;
                                evpage_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= 1'b1;
                    pidx_reg <= cnt_reg;
                    pfv_reg  <= valid_reg[cnt_reg];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == ftlru_pkg::IDX_BITS'(ftlru_pkg::FRAME_COUNT - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    done_reg   <= 1'b1;
                    chosen_reg <= fill_ok ? 6'(fill_idx) : 6'd0;
                    nf_reg     <= !fill_ok;
                    ev_reg     <= fill_ok && fill_evict;
                    evpid_reg  <= (fill_ok && fill_evict) ? 8'(srch.best_owner) : 8'd0;
                    evpage_reg <= (fill_ok && fill_evict) ? 10'(srch.best_page) : 10'd0;
                    if (fill_ok)
                    begin
                        valid_reg[fill_idx] <= 1'b1;
                        if (!fill_evict)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                ST_FETCH:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    done_reg   <= 1'b1;
                    chosen_reg <= idx_reg;
                    nf_reg     <= 1'b0;
                    ev_reg     <= 1'b0;
                    evpid_reg  <= '0;
                    evpage_reg <= '0;
                    if (kind_reg == ftlru_pkg::KIND_RELEASE && hit)
                    begin
                        ev_reg               <= 1'b1;
                        evpid_reg            <= 8'(rd_entry.owner);
                        evpage_reg           <= 10'(rd_entry.page);
                        valid_reg[req_addr]  <= 1'b0;
                        if (count_reg != '0)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign chosen_frame  = chosen_reg;
    assign not_found     = nf_reg;
    assign evicted_valid = ev_reg;
    assign evicted_pid   = evpid_reg;
    assign evicted_page  = evpage_reg;
    assign frames_in_use = 7'(count_reg);

endmodule
